@@ sv/ppg_led_current_auto_exposure_top_macros.svh @@
// -----------------------------------------------------------------------------
// ppg_led_current_auto_exposure_top_macros.svh
// Assertion macros shared by the LED auto-exposure block.
// -----------------------------------------------------------------------------
`ifndef PPG_LED_CURRENT_AUTO_EXPOSURE_TOP_MACROS_SVH
`define PPG_LED_CURRENT_AUTO_EXPOSURE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define PPGAE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define PPGAE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ppgae_pkg.sv @@
// -----------------------------------------------------------------------------
// ppgae_pkg
// Types, constants and register codes of the LED auto-exposure block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppgae_pkg;

  localparam int SETTLE_FRAMES = 3;
  localparam int FC_W          = $clog2(SETTLE_FRAMES + 2);

  localparam int EXPO_W = 10;
  localparam int CUR_W  = 5;
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 3;

  localparam logic [7:0]       LED_ON_BASE  = 8'hE0;
  localparam logic [7:0]       LED_SLEEP    = 8'hFF;
  localparam logic [CUR_W-1:0] MIRROR_SLEEP = 5'h1F;

  typedef enum logic [IDX_W-1:0] {
    CFG_ENTER_HIGH  = 3'd0,
    CFG_ENTER_LOW   = 3'd1,
    CFG_STAY_HIGH   = 3'd2,
    CFG_STAY_LOW    = 3'd3,
    CFG_STEP        = 3'd4,
    CFG_CUR_MAX     = 3'd5,
    CFG_CUR_MIN     = 3'd6,
    CFG_CUR_DEFAULT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [EXPO_W-1:0] enter_high_bound;
    logic [EXPO_W-1:0] enter_low_bound;
    logic [EXPO_W-1:0] stay_high_level;
    logic [EXPO_W-1:0] stay_low_level;
    logic [CUR_W-1:0]  step_size;
    logic [CUR_W-1:0]  current_max;
    logic [CUR_W-1:0]  current_min;
    logic [CUR_W-1:0]  default_current;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enter_high_bound: 10'd496,
    enter_low_bound:  10'd32,
    stay_high_level:  10'd420,
    stay_low_level:   10'd64,
    step_size:        5'd2,
    current_max:      5'd31,
    current_min:      5'd1,
    default_current:  5'd10
  };

  typedef enum logic [2:0] {
    PH_HOLD  = 3'b001,
    PH_RAISE = 3'b010,
    PH_LOWER = 3'b100
  } phase_t;

  typedef struct packed {
    logic       current_changed;
    logic       sensor_active;
    logic [7:0] led_value;
    logic       led_write;
  } result_t;

endpackage

@@ sv/ppgae_cfg.sv @@
// -----------------------------------------------------------------------------
// ppgae_cfg
// Configuration register file: thresholds, step size, current limits and default current.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppgae_cfg import ppgae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENTER_HIGH:  cfg.enter_high_bound <= cfg_data[EXPO_W-1:0];
        CFG_ENTER_LOW:   cfg.enter_low_bound  <= cfg_data[EXPO_W-1:0];
        CFG_STAY_HIGH:   cfg.stay_high_level  <= cfg_data[EXPO_W-1:0];
        CFG_STAY_LOW:    cfg.stay_low_level   <= cfg_data[EXPO_W-1:0];
        CFG_STEP:        cfg.step_size        <= cfg_data[CUR_W-1:0];
        CFG_CUR_MAX:     cfg.current_max      <= cfg_data[CUR_W-1:0];
        CFG_CUR_MIN:     cfg.current_min      <= cfg_data[CUR_W-1:0];
        CFG_CUR_DEFAULT: cfg.default_current  <= cfg_data[CUR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/ppgae_core.sv @@
// -----------------------------------------------------------------------------
// ppgae_core
// Per-frame exposure decision and the state it carries from frame to frame.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppgae_core import ppgae_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              advance,
  input  logic              touched,
  input  logic [EXPO_W-1:0] expo_count,
  output result_t           res
);

  phase_t            phase, phase_next;
  logic [FC_W-1:0]   frame_count, frame_count_next;
  logic [CUR_W-1:0]  led_current, led_current_next;
  logic [CUR_W-1:0]  led_mirror, led_mirror_next;
  logic              asleep, asleep_next;

  always_comb begin
    logic [CUR_W-1:0] mir_eff;
    logic [CUR_W-1:0] cur_new;
    logic [CUR_W:0]   sum_mir;
    logic [CUR_W:0]   sum_cur;
    logic [CUR_W:0]   low_lim;
    logic             hit_high;
    logic             hit_low;
    logic             adj;
    logic             clamp;

    phase_next       = phase;
    frame_count_next = frame_count;
    led_current_next = led_current;
    led_mirror_next  = led_mirror;
    asleep_next      = asleep;
    res              = '0;
    res.sensor_active = touched;
    cur_new          = led_current;
    adj              = 1'b0;
    clamp            = 1'b0;

    // a wake write in this frame overrides whatever the mirror held
    mir_eff  = asleep ? cfg.default_current : led_mirror;
    sum_mir  = {1'b0, mir_eff} + {1'b0, cfg.step_size};
    sum_cur  = {1'b0, led_current} + {1'b0, cfg.step_size};
    low_lim  = {1'b0, cfg.current_min} + {1'b0, cfg.step_size};
    hit_high = expo_count >= cfg.enter_high_bound;
    hit_low  = expo_count <= cfg.enter_low_bound;

    if (touched) begin
      if (asleep) begin
        res.led_write   = 1'b1;
        res.led_value   = LED_ON_BASE | {3'b000, cfg.default_current};
        led_mirror_next = cfg.default_current;
        asleep_next     = 1'b0;
      end
      if (frame_count <= FC_W'(SETTLE_FRAMES)) begin
        frame_count_next = frame_count + 1'b1;
      end else begin
        frame_count_next = '0;
        case (phase)
          PH_HOLD: begin
            if (hit_high || hit_low) begin
              led_current_next = mir_eff;
            end
            if (hit_high && (mir_eff < cfg.current_max)) begin
              phase_next = PH_RAISE;
              cur_new = (sum_mir > {1'b0, cfg.current_max}) ? cfg.current_max
                                                            : sum_mir[CUR_W-1:0];
              adj = 1'b1;
            end else if (hit_low && (mir_eff > cfg.current_min)) begin
              phase_next = PH_LOWER;
              cur_new = ({1'b0, mir_eff} <= low_lim) ? cfg.current_min
                                                     : mir_eff - cfg.step_size;
              adj = 1'b1;
            end
          end
          PH_RAISE: begin
            if (expo_count > cfg.stay_high_level) begin
              if (sum_cur >= {1'b0, cfg.current_max}) begin
                phase_next = PH_HOLD;
                cur_new    = cfg.current_max;
              end else begin
                cur_new = sum_cur[CUR_W-1:0];
              end
              adj = 1'b1;
            end else begin
              phase_next = PH_HOLD;
            end
          end
          default: begin
            if (expo_count < cfg.stay_low_level) begin
              clamp      = {1'b0, led_current} <= low_lim;
              cur_new    = clamp ? cfg.current_min : led_current - cfg.step_size;
              phase_next = clamp ? PH_HOLD : PH_LOWER;
              adj        = 1'b1;
            end else begin
              phase_next = PH_HOLD;
            end
          end
        endcase
        if (adj) begin
          led_current_next    = cur_new;
          led_mirror_next     = cur_new;
          res.led_write       = 1'b1;
          res.led_value       = LED_ON_BASE | {3'b000, cur_new};
          res.current_changed = 1'b1;
        end
      end
    end else begin
      led_current_next = cfg.default_current;
      led_mirror_next  = MIRROR_SLEEP;
      asleep_next      = 1'b1;
      res.led_write    = 1'b1;
      res.led_value    = LED_SLEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HOLD;
      frame_count <= '0;
      led_current <= CFG_RESET.default_current;
      asleep      <= 1'b1;
    end else if (advance) begin
      phase       <= phase_next;
      frame_count <= frame_count_next;
      led_current <= led_current_next;
      asleep      <= asleep_next;
    end
  end

  // mirror is only read after a write in the same or an earlier frame
  always_ff @(posedge clk) begin
    if (advance) begin
      led_mirror <= led_mirror_next;
    end
  end

endmodule

@@ sv/ppg_led_current_auto_exposure_top.sv @@
// One frame word in, one result word out. Each accepted word (touch flag and
// 10-bit exposure) sits in an input register, the frame decision is made by
// combinational compare and add logic, and the result lands in an output
// register. A new frame is taken every cycle while m_tready stays high, and
// every frame goes through a single decision path. While a result waits for
// m_tready the input register still takes one more word; with both registers
// full, s_tready drops until the result is taken. Configuration writes take
// effect at the next clock edge and should only be issued while no frame is
// in flight.
// -----------------------------------------------------------------------------
// ppg_led_current_auto_exposure_top
// LED drive-current auto-exposure for an optical pulse sensor, one frame a word.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ppg_led_current_auto_exposure_top_macros.svh"

module ppg_led_current_auto_exposure_top import ppgae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [0] touched, [10:1] expo_count, [15:11] zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata    // [0] led_write, [8:1] led_value,
                                      // [9] sensor_active, [10] current_changed,
                                      // [15:11] zero
);

  cfg_t              cfg;
  logic              in_valid;
  logic              in_touched;
  logic [EXPO_W-1:0] in_expo;
  logic              advance;
  result_t           res;
  result_t           out_res;

  ppgae_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppgae_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .touched    (in_touched),
    .expo_count (in_expo),
    .res        (res)
  );

  // advance the frame when an input word is held and the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_touched <= s_tdata[0];
      in_expo    <= s_tdata[EXPO_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b00000, out_res};

  `PPGAE_ASSERT_IMP(a_change_implies_write, m_tvalid && out_res.current_changed, out_res.led_write, "current change without LED write")
  `PPGAE_ASSERT_IMP(a_untouched_sleep_byte, m_tvalid && !out_res.sensor_active, out_res.led_write && (out_res.led_value == LED_SLEEP), "untouched frame did not write sleep byte")
  `PPGAE_ASSERT_IMP(a_ready_when_drained, !m_tvalid, s_tready, "input stalled with empty result register")
  `PPGAE_ASSERT_NXT(a_advance_fills_output, advance, m_tvalid, "advanced frame did not reach result register")

endmodule
